// ----- design/pap_pkg.sv -----
// shared types, codes and sizes for the positional insert array
package pap_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;

    localparam logic [2:0] CMD_READ   = 3'd0;
    localparam logic [2:0] CMD_AT     = 3'd1;
    localparam logic [2:0] CMD_BEFORE = 3'd2;
    localparam logic [2:0] CMD_AFTER  = 3'd3;
    localparam logic [2:0] CMD_FRONT  = 3'd4;
    localparam logic [2:0] CMD_END    = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [7:0]  position;
        logic signed [31:0] item_value;
    } in_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         entry_count;
        logic [1:0]         status;
    } out_t;

    // decoded request
    typedef struct packed {
        logic             rd_ok;
        logic             ins_ok;
        logic [IDX_W-1:0] slot;
        logic [1:0]       status;
    } chk_t;

    // one write and one read per cycle
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [31:0]      wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

endpackage

// ----- design/positional_insert_array.sv -----
// top level: ordered entry store with positional insert and read, one request at a time
//
// A request transfer happens at a rising edge with start high and busy low. Each
// request gives exactly one result, shown on result with done high for one cycle,
// the cycle after the request finishes; the receiver cannot stall it, so it must
// take the result in that cycle. A request that fails its index check or meets a
// full store, and an insert at the end (slot equal to the count), finishes in
// its transfer cycle. A read waits on the registered read port of the entry memory.
// An insert moves the tail above its slot up one entry per cycle through the
// memory's single read and write port pair, then writes the new value into the
// gap. busy is high while the tail moves and the new value is written. The
// store holds CAPACITY entries; entries have no reset value and only entries below
// the count are ever read.
module positional_insert_array
    import pap_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  in_t  request,
    output logic busy,
    output logic done,
    output out_t result
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_PLACE = 2'd2;
    localparam logic [1:0] S_READ  = 2'd3;

    logic [1:0]       state_reg,  state_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] slot_reg,   slot_next;
    logic [31:0]      val_reg,    val_next;
    logic             done_reg,   done_next;
    out_t             result_reg, result_next;

    chk_t             chk;
    mem_req_t         mreq;
    logic [31:0]      rd_data;
    logic [IDX_W-1:0] dec_idx;
    logic             accept;
    logic [CNT_W-1:0] count_inc;

    pap_check u_check
    (
        .request (request),
        .count   (count_reg),
        .chk     (chk)
    );

    pap_mem u_mem
    (
        .clk     (clk),
        .req     (mreq),
        .rd_data (rd_data)
    );

    assign accept    = start && (state_reg == S_IDLE);
    // shared decrement and compare that walks the tail downward
    assign dec_idx   = wr_idx_reg - IDX_W'(1);
    assign count_inc = count_reg + CNT_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        wr_idx_next = wr_idx_reg;
        slot_next   = slot_reg;
        val_next    = val_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        mreq        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    slot_next = chk.slot;
                    val_next  = request.item_value;
                    if (chk.rd_ok)
                    begin
                        mreq.rd_en   = 1'b1;
                        mreq.rd_addr = chk.slot;
                        state_next   = S_READ;
                    end
                    else if (chk.ins_ok && CNT_W'(chk.slot) == count_reg)
                    begin
                        // append: no tail to move
                        mreq.wr_en              = 1'b1;
                        mreq.wr_addr            = chk.slot;
                        mreq.wr_data            = request.item_value;
                        count_next              = count_inc;
                        done_next               = 1'b1;
                        result_next.read_value  = '0;
                        result_next.entry_count = 7'(count_inc);
                        result_next.status      = ST_OK;
                    end
                    else if (chk.ins_ok)
                    begin
                        // fetch the last entry, it moves first
                        mreq.rd_en   = 1'b1;
                        mreq.rd_addr = IDX_W'(count_reg - CNT_W'(1));
                        wr_idx_next  = IDX_W'(count_reg);
                        state_next   = S_SHIFT;
                    end
                    else
                    begin
                        done_next               = 1'b1;
                        result_next.read_value  = '0;
                        result_next.entry_count = 7'(count_reg);
                        result_next.status      = chk.status;
                    end
                end
            end
            S_SHIFT:
            begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = wr_idx_reg;
                mreq.wr_data = rd_data;
                if (dec_idx == slot_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = dec_idx - IDX_W'(1);
                    wr_idx_next  = dec_idx;
                end
            end
            S_PLACE:
            begin
                mreq.wr_en              = 1'b1;
                mreq.wr_addr            = slot_reg;
                mreq.wr_data            = val_reg;
                count_next              = count_inc;
                done_next               = 1'b1;
                result_next.read_value  = '0;
                result_next.entry_count = 7'(count_inc);
                result_next.status      = ST_OK;
                state_next              = S_IDLE;
            end
            S_READ:
            begin
                done_next               = 1'b1;
                result_next.read_value  = rd_data;
                result_next.entry_count = 7'(count_reg);
                result_next.status      = ST_OK;
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        wr_idx_reg <= wr_idx_next;
        slot_reg   <= slot_next;
        val_reg    <= val_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // count stays within the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(count_reg) <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    // count only ever grows by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("count changed by other than one");

    // tail walk stays above the insertion slot
    a_shift_above_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (wr_idx_reg > slot_reg))
        else $error("shift index at or below slot");

    // read and write never hit the same entry while shifting
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && mreq.rd_en) |-> (mreq.rd_addr != mreq.wr_addr))
        else $error("read and write address clash");

    // a result only follows the place or read state or a cycle that accepted a request
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_PLACE || $past(state_reg) == S_READ
                  || $past(accept)))
        else $error("done without a finishing request");

endmodule

// ----- design/pap_mem.sv -----
// entry store: one write port, one registered read port
module pap_mem
    import pap_pkg::*;
(
    input  logic        clk,
    input  mem_req_t    req,
    output logic [31:0] rd_data
);

    logic [31:0] mem [CAPACITY];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/pap_check.sv -----
// command decode and index range check against the current count
module pap_check
    import pap_pkg::*;
(
    input  in_t              request,
    input  logic [CNT_W-1:0] count,
    output chk_t             chk
);

    logic             pos_neg;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic [CMP_W-1:0] slot_c;
    logic             ins;
    logic             rd;
    logic [1:0]       st;

    always_comb
    begin
        pos_neg = request.position[7];
        pos_c   = CMP_W'(request.position[6:0]);
        cnt_c   = CMP_W'(count);
        slot_c  = '0;
        ins     = 1'b0;
        rd      = 1'b0;
        st      = ST_OK;
        case (request.cmd)
            CMD_READ:
            begin
                if (pos_neg || pos_c >= cnt_c) st = ST_RANGE;
                else
                begin
                    rd     = 1'b1;
                    slot_c = pos_c;
                end
            end
            CMD_AT:
            begin
                if (pos_neg || pos_c > cnt_c) st = ST_RANGE;
                else
                begin
                    ins    = 1'b1;
                    slot_c = pos_c;
                end
            end
            CMD_BEFORE:
            begin
                if (pos_neg || pos_c >= cnt_c) st = ST_RANGE;
                else
                begin
                    ins    = 1'b1;
                    slot_c = pos_c;
                end
            end
            CMD_AFTER:
            begin
                if (pos_neg || pos_c >= cnt_c) st = ST_RANGE;
                else
                begin
                    ins    = 1'b1;
                    slot_c = pos_c + CMP_W'(1);
                end
            end
            CMD_FRONT:
            begin
                ins    = 1'b1;
                slot_c = '0;
            end
            CMD_END:
            begin
                ins    = 1'b1;
                slot_c = cnt_c;
            end
            default:
            begin
                st = ST_RANGE;
            end
        endcase
        // index first, free space second
        if (ins && cnt_c >= CMP_W'(CAPACITY))
        begin
            ins = 1'b0;
            st  = ST_FULL;
        end
        chk.rd_ok  = rd;
        chk.ins_ok = ins;
        chk.slot   = IDX_W'(slot_c);
        chk.status = st;
    end

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for the positional insert array: shadow store, random requests, idle phases
module testbench;
    import pap_pkg::*;

    // command codes the block does not know; they must answer out of range
    localparam logic [2:0] CMD_BAD_LO = 3'd6;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;

    // random requests per idle phase, and the number of phases
    localparam int PHASE_ITEMS = 375;
    localparam int NUM_PHASES  = 3;
    // cycles with no transfer on either side before the run is declared hung
    localparam int STALL_LIMIT = 2000;

    // shadow copy of the store: predicts the reply to each request and checks
    // replies in order against it
    class insert_array_shadow;
        logic signed [31:0] slots [CAPACITY];
        int                 fill;
        out_t               pending_replies [$];
        int                 mismatches;
        int                 n_requests;
        int                 n_reads;
        int                 n_inserts;
        int                 n_range;
        int                 n_full;

        function new();
            fill       = 0;
            mismatches = 0;
            n_requests = 0;
            n_reads    = 0;
            n_inserts  = 0;
            n_range    = 0;
            n_full     = 0;
        endfunction

        // work out the reply to an accepted request and update the shadow
        function void note_request(in_t req);
            out_t want;
            int   pos;
            int   slot;
            int   k;
            bit   neg;
            bit   do_insert;
            want        = '0;
            want.status = ST_OK;
            neg         = req.position[7];
            pos         = int'(req.position);
            slot        = 0;
            do_insert   = 1'b0;
            case (req.cmd)
                CMD_READ:
                begin
                    if (neg || pos >= fill)
                        want.status = ST_RANGE;
                    else
                    begin
                        want.read_value = slots[pos];
                        n_reads++;
                    end
                end
                CMD_AT:
                begin
                    // index may equal the count, which appends
                    if (neg || pos > fill)
                        want.status = ST_RANGE;
                    else
                    begin
                        slot      = pos;
                        do_insert = 1'b1;
                    end
                end
                CMD_BEFORE:
                begin
                    if (neg || pos >= fill)
                        want.status = ST_RANGE;
                    else
                    begin
                        slot      = pos;
                        do_insert = 1'b1;
                    end
                end
                CMD_AFTER:
                begin
                    if (neg || pos >= fill)
                        want.status = ST_RANGE;
                    else
                    begin
                        slot      = pos + 1;
                        do_insert = 1'b1;
                    end
                end
                CMD_FRONT:
                begin
                    slot      = 0;
                    do_insert = 1'b1;
                end
                CMD_END:
                begin
                    slot      = fill;
                    do_insert = 1'b1;
                end
                default:
                    want.status = ST_RANGE;
            endcase
            // index is checked before free space
            if (do_insert)
            begin
                if (fill >= CAPACITY)
                    want.status = ST_FULL;
                else
                begin
                    for (k = fill; k > slot; k--)
                        slots[k] = slots[k - 1];
                    slots[slot] = req.item_value;
                    fill++;
                    n_inserts++;
                end
            end
            if (want.status == ST_RANGE)
                n_range++;
            if (want.status == ST_FULL)
                n_full++;
            n_requests++;
            want.entry_count = 7'(fill);
            pending_replies.push_back(want);
        endfunction

        // compare one reply with the oldest prediction
        function void check_result(out_t got);
            out_t want;
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: read_value %0d entry_count %0d status %0d",
                         $time, got.read_value, got.entry_count, got.status);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.read_value !== want.read_value)
                begin
                    mismatches++;
                    $display("%0t: read_value mismatch: expected %0d, actual %0d",
                             $time, want.read_value, got.read_value);
                end
                if (got.entry_count !== want.entry_count)
                begin
                    mismatches++;
                    $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                             $time, want.entry_count, got.entry_count);
                end
                if (got.status !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, got.status);
                end
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_t  request = '0;
    logic busy;
    logic done;
    out_t result;

    insert_array_shadow shadow = new();
    int                 quiet_cycles = 0;
    int                 idle_pct [NUM_PHASES] = '{0, 59, 37};

    positional_insert_array dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // 4 time unit clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // every reply is taken in its single done cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.check_result(result);
    end

    // hang detection: count cycles with neither a request nor a reply transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // present one request after a random idle gap, hold it until the block
    // takes it; inputs move only on the falling edge
    task automatic send_request(input in_t req, input int idle_chance);
        while ($urandom_range(99) < idle_chance)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start   = 1'b1;
        request = req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // transfer happened at this edge
        shadow.note_request(req);
    endtask

    // back-to-back request with explicit fields
    task automatic send_fields(input logic [2:0] c, input int p, input logic [31:0] v);
        in_t req;
        req.cmd        = c;
        req.position   = 8'(p);
        req.item_value = v;
        send_request(req, 0);
    endtask

    // mostly well-formed requests: reads dominate, inserts are rare enough that
    // the store fills late in the run; some indexes are random to hit range errors
    function automatic in_t random_request();
        in_t req;
        int  pick;
        int  n;
        n            = shadow.fill;
        req.position = 8'($urandom);
        if ($urandom_range(9) == 0)
        begin
            case ($urandom_range(3))
                0: req.item_value = 32'h8000_0000;
                1: req.item_value = 32'h7fff_ffff;
                2: req.item_value = 32'h0000_0000;
                default: req.item_value = 32'hffff_ffff;
            endcase
        end
        else
            req.item_value = $urandom;
        pick = $urandom_range(99);
        if (pick < 4)
            req.cmd = $urandom_range(1) ? CMD_BAD_HI : CMD_BAD_LO;
        else if (pick < 14)
        begin
            req.cmd = 3'($urandom_range(int'(CMD_END), int'(CMD_AT)));
            if ($urandom_range(4) != 0)
            begin
                if (req.cmd == CMD_AT)
                    req.position = 8'($urandom_range(n, 0));
                else if (n > 0)
                    req.position = 8'($urandom_range(n - 1, 0));
            end
        end
        else
        begin
            req.cmd = CMD_READ;
            if (n > 0 && $urandom_range(6) != 0)
                req.position = 8'($urandom_range(n - 1, 0));
        end
        return req;
    endfunction

    initial
    begin
        int ph;
        int i;

        // reset once, then release it on a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty store, every insert kind, index edges, value extremes
        send_fields(CMD_READ,   0,    32'h0);
        send_fields(CMD_BEFORE, 0,    32'h1234_5678);
        send_fields(CMD_AFTER,  0,    32'h1234_5678);
        send_fields(CMD_AT,     1,    32'h1234_5678);
        send_fields(CMD_AT,     0,    32'h7fff_ffff);
        send_fields(CMD_FRONT,  -128, 32'h8000_0000);
        send_fields(CMD_END,    127,  32'h0000_0000);
        send_fields(CMD_BEFORE, 1,    32'hffff_ffff);
        send_fields(CMD_AFTER,  3,    32'h0000_0001);
        send_fields(CMD_AT,     5,    32'h5555_5555);
        send_fields(CMD_AT,     -1,   32'h0bad_0bad);
        send_fields(CMD_AT,     7,    32'h0bad_0bad);
        send_fields(CMD_READ,   -128, 32'hffff_ffff);
        send_fields(CMD_READ,   127,  32'h0);
        send_fields(CMD_READ,   6,    32'h0);
        for (i = 0; i < 6; i++)
            send_fields(CMD_READ, i, 32'h0);
        send_fields(CMD_BAD_LO, 0,    32'h1);
        send_fields(CMD_BAD_HI, 2,    32'h1);
        send_fields(CMD_AFTER,  6,    32'h0bad_0bad);
        send_fields(CMD_FRONT,  0,    32'haaaa_aaaa);

        // random phases: no idling, heavy sender gaps, moderate sender gaps
        for (ph = 0; ph < NUM_PHASES; ph++)
            for (i = 0; i < PHASE_ITEMS; i++)
                send_request(random_request(), idle_pct[ph]);

        @(negedge clk);
        start = 1'b0;

        // drain outstanding replies, then give the block time for a stray one
        while (shadow.pending_replies.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 4) @(posedge clk);

        $display("covered %0d requests: %0d good reads, %0d inserts, %0d index rejects, %0d full rejects",
                 shadow.n_requests, shadow.n_reads, shadow.n_inserts, shadow.n_range,
                 shadow.n_full);
        $display("store held %0d entries at the end, %0d mismatches seen",
                 shadow.fill, shadow.mismatches);
        if (shadow.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/pap_pkg.sv
design/pap_mem.sv
design/pap_check.sv
design/positional_insert_array.sv
bench/testbench.sv
